// File: hw/rtl/bounded_top_k_min_heap_assert.svh
// Assertion macros for the bounded top-k heap.
// Both expect clk and arst_n in scope.
`ifndef BOUNDED_TOP_K_MIN_HEAP_ASSERT_SVH
`define BOUNDED_TOP_K_MIN_HEAP_ASSERT_SVH

// condition holds at every edge out of reset
`define BTKH_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("%m: check failed");

// antecedent at one edge implies consequent at the next
`define BTKH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// File: hw/rtl/bthm_pkg.sv
`default_nettype none

package bthm_pkg;

	localparam int SCORE_BITS    = 32;
	localparam int TAG_PORT_BITS = 32;
	localparam int CAP_BITS      = 7;
	localparam int DEPTH_DEF     = 64;
	localparam int TAG_BITS_DEF  = 32;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

	// opcodes
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]                    opcode;
		logic signed [SCORE_BITS-1:0]  entry_score;
		logic [TAG_PORT_BITS-1:0]      entry_tag;
	} in_item_t;

	typedef struct packed {
		logic signed [SCORE_BITS-1:0]  root_score;
		logic [TAG_PORT_BITS-1:0]      root_tag;
		logic [CAP_BITS-1:0]           entry_count;
		logic                          is_empty;
		logic                          was_kept;
		logic                          pop_error;
	} out_item_t;

	// per-level memory request
	typedef struct packed {
		logic rd;
		logic wr;
		logic wr_odd;
	} cell_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/bounded_top_k_min_heap.sv
// A clear, a dropped push, the unused opcode or a pop error goes straight to the finish state;
// each level an entry moves takes a memory read, then a compare and write. One item at a
// time: the next start is taken at the edge that ends the done cycle. Results cannot be stalled.
// Reset (arst_n low, async): heap empty, capacity 64; entry memories are not cleared.
`default_nettype none

module bounded_top_k_min_heap import bthm_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// command side: item taken when start is high and busy low
	input  wire logic                 start,
	output logic                      busy,
	input  wire in_item_t             cmd,
	// result side: one-cycle strobe, no back-pressure
	output logic                      done,
	output out_item_t                 result,
	// capacity register write
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CAP_BITS-1:0]  cfg_data
);

	localparam int NLEV = $clog2(DEPTH + 1);
	localparam int KW   = NLEV - 1;
	localparam int EW   = SCORE_BITS + TAG_BITS;

	logic [NLEV-1:0] rd_sel;
	logic [NLEV-1:0] wr_sel;
	logic [KW-1:0]   rd_row;
	logic [KW-1:0]   wr_row;
	logic            wr_odd;
	logic [EW-1:0]   wr_data;
	logic [EW-1:0]   rd_even;
	logic [EW-1:0]   rd_odd;

	logic [EW-1:0]   cell_even [NLEV];
	logic [EW-1:0]   cell_odd  [NLEV];
	cell_cmd_t       cell_cmd  [NLEV];

	// Sequencer: holds count, capacity, root copy and the entry being sifted.
	bthm_ctrl #(
		.DEPTH    (DEPTH),
		.TAG_BITS (TAG_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.rd_sel    (rd_sel),
		.rd_row    (rd_row),
		.wr_sel    (wr_sel),
		.wr_row    (wr_row),
		.wr_odd    (wr_odd),
		.wr_data   (wr_data),
		.rd_even   (rd_even),
		.rd_odd    (rd_odd)
	);

	// Row of level cells. Level i holds heap positions 2^i-1 onwards, capped
	// at DEPTH, stored as sibling pairs so both children come in one read.
	for (genvar i = 0; i < NLEV; i++) begin : g_level
		localparam int LBASE = (1 << i) - 1;
		localparam int LENT  = ((DEPTH - LBASE) < (1 << i)) ? (DEPTH - LBASE) : (1 << i);
		localparam int LROWS = (LENT + 1) / 2;

		assign cell_cmd[i] = '{rd: rd_sel[i], wr: wr_sel[i], wr_odd: wr_odd};

		bthm_level #(
			.ROWS (LROWS),
			.EW   (EW),
			.KW   (KW)
		) u_level (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cell_cmd[i]),
			.rd_row  (rd_row),
			.wr_row  (wr_row),
			.wr_data (wr_data),
			.rd_even (cell_even[i]),
			.rd_odd  (cell_odd[i])
		);
	end

	// Only the level read last cycle drives non-zero data, so OR them together.
	always_comb begin
		rd_even = '0;
		rd_odd  = '0;
		for (int i = 0; i < NLEV; i++) begin
			rd_even = rd_even | cell_even[i];
			rd_odd  = rd_odd  | cell_odd[i];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/bthm_level.sv
`default_nettype none

// One heap level: entries stored as sibling pairs, even and odd halves.
module bthm_level import bthm_pkg::*; #(
	parameter int ROWS = 1,
	parameter int EW   = 64,
	parameter int KW   = 6
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cell_cmd_t       cmd,
	input  wire logic [KW-1:0]   rd_row,
	input  wire logic [KW-1:0]   wr_row,
	input  wire logic [EW-1:0]   wr_data,
	output logic [EW-1:0]        rd_even,
	output logic [EW-1:0]        rd_odd
);

	localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [EW-1:0] mem_even [ROWS];
	logic [EW-1:0] mem_odd  [ROWS];
	logic [EW-1:0] even_q;
	logic [EW-1:0] odd_q;
	logic          hit_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			if (cmd.wr_odd) begin
				mem_odd[wr_row[RIW-1:0]] <= wr_data;
			end else begin
				mem_even[wr_row[RIW-1:0]] <= wr_data;
			end
		end
		if (cmd.rd) begin
			even_q <= mem_even[rd_row[RIW-1:0]];
			odd_q  <= mem_odd[rd_row[RIW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= cmd.rd;
		end
	end

	// only the level last read drives the shared read bus
	assign rd_even = hit_q ? even_q : '0;
	assign rd_odd  = hit_q ? odd_q  : '0;

endmodule

`default_nettype wire

// File: hw/rtl/bthm_ctrl.sv
`default_nettype none

`include "bounded_top_k_min_heap_assert.svh"

// Sift sequencer: carries the moving entry level to level.
module bthm_ctrl import bthm_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF,
	localparam int NLEV    = $clog2(DEPTH + 1),
	localparam int KW      = NLEV - 1,
	localparam int EW      = SCORE_BITS + TAG_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire in_item_t             cmd,
	output logic                      done,
	output out_item_t                 result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CAP_BITS-1:0]  cfg_data,
	output logic [NLEV-1:0]           rd_sel,
	output logic [KW-1:0]             rd_row,
	output logic [NLEV-1:0]           wr_sel,
	output logic [KW-1:0]             wr_row,
	output logic                      wr_odd,
	output logic [EW-1:0]             wr_data,
	input  wire logic [EW-1:0]        rd_even,
	input  wire logic [EW-1:0]        rd_odd
);

	localparam int CW  = NLEV;
	localparam int PW  = $clog2(DEPTH);
	localparam int LVW = $clog2(NLEV + 1);
	localparam int LW  = (CW > CAP_BITS) ? CW : CAP_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_POP_RD, S_POP_LD, S_FIN
	} state_t;

	function automatic logic lower(input logic [EW-1:0] a, input logic [EW-1:0] b);
		return $signed(a[EW-1 -: SCORE_BITS]) < $signed(b[EW-1 -: SCORE_BITS]);
	endfunction

	state_t                state_q;
	logic [CAP_BITS-1:0]   cap_q;
	logic [CW-1:0]         cnt_q;
	logic [LVW-1:0]        tail_lvl_q;
	logic [KW-1:0]         tail_k_q;
	logic [LVW-1:0]        lvl_q;
	logic [KW-1:0]         k_q;
	logic [PW-1:0]         pos_q;
	logic [EW-1:0]         x_q;
	logic [EW-1:0]         root_q;
	logic                  kept_q;
	logic                  perr_q;
	logic                  done_q;
	out_item_t             result_q;

	logic [LW-1:0]   cap_ext;
	logic [LW-1:0]   cnt_ext;
	logic [LW-1:0]   lim;
	logic            has_room;
	logic [EW-1:0]   new_entry;
	logic [KW:0]     k_ext;
	logic [EW-1:0]   parent;
	logic            x_lt_p;
	logic [PW+1:0]   l_pos;
	logic [PW+1:0]   r_pos;
	logic [PW+1:0]   n_ext;
	logic            l_ok;
	logic            r_ok;
	logic            go_l;
	logic            go_r;
	logic [EW-1:0]   best;
	logic            rd_en;
	logic [LVW-1:0]  rd_lvl;
	logic            wr_en;
	logic [LVW-1:0]  wr_lvl;

	assign cap_ext   = LW'(cap_q);
	assign cnt_ext   = LW'(cnt_q);
	assign lim       = (cap_q == '0) ? LW'(1) :
	                   (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
	assign has_room  = cnt_ext < lim;
	assign new_entry = {cmd.entry_score, cmd.entry_tag[TAG_BITS-1:0]};

	// parent of (lvl, k) is (lvl-1, k>>1): row k>>2, half bit 1 of k
	assign k_ext  = {1'b0, k_q};
	assign parent = k_ext[1] ? rd_odd : rd_even;
	assign x_lt_p = lower(x_q, parent);

	assign l_pos = (PW + 2)'({pos_q, 1'b1});
	assign r_pos = l_pos + (PW + 2)'(1);
	assign n_ext = (PW + 2)'(cnt_q);
	assign l_ok  = l_pos < n_ext;
	assign r_ok  = r_pos < n_ext;

	// children sit as one pair row; ties keep the parent, then the left child
	assign go_l = lower(rd_even, x_q);
	assign best = go_l ? rd_even : x_q;
	assign go_r = r_ok && lower(rd_odd, best);

	always_comb begin
		rd_en   = 1'b0;
		rd_lvl  = '0;
		rd_row  = '0;
		wr_en   = 1'b0;
		wr_lvl  = lvl_q;
		wr_row  = KW'(k_q >> 1);
		wr_odd  = k_q[0];
		wr_data = x_q;
		case (state_q)
			S_UP_RD: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en  = 1'b1;
					rd_lvl = lvl_q - LVW'(1);
					rd_row = KW'(k_q >> 2);
				end
			end
			S_UP_CMP: begin
				wr_en   = 1'b1;
				wr_data = x_lt_p ? parent : x_q;
			end
			S_DN_RD: begin
				if (l_ok) begin
					rd_en  = 1'b1;
					rd_lvl = lvl_q + LVW'(1);
					rd_row = k_q;
				end else begin
					wr_en = 1'b1;
				end
			end
			S_DN_CMP: begin
				wr_en   = 1'b1;
				wr_data = go_r ? rd_odd : (go_l ? rd_even : x_q);
			end
			S_POP_RD: begin
				if (cnt_q != '0) begin
					rd_en  = 1'b1;
					rd_lvl = tail_lvl_q;
					rd_row = KW'(tail_k_q >> 1);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < NLEV; i++) begin
			rd_sel[i] = rd_en && (rd_lvl == LVW'(i));
			wr_sel[i] = wr_en && (wr_lvl == LVW'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cap_q      <= CAP_RESET;
			cnt_q      <= '0;
			tail_lvl_q <= '0;
			tail_k_q   <= '0;
			lvl_q      <= '0;
			k_q        <= '0;
			pos_q      <= '0;
			x_q        <= '0;
			root_q     <= '0;
			kept_q     <= 1'b0;
			perr_q     <= 1'b0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (wr_en && (wr_lvl == '0)) begin
				root_q <= wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						cap_q <= cfg_data;
					end
					if (start) begin
						x_q    <= new_entry;
						kept_q <= 1'b0;
						perr_q <= 1'b0;
						state_q <= S_FIN;
						case (cmd.opcode)
							OP_PUSH: begin
								if (has_room) begin
									kept_q  <= 1'b1;
									lvl_q   <= tail_lvl_q;
									k_q     <= tail_k_q;
									pos_q   <= PW'(cnt_q);
									cnt_q   <= cnt_q + CW'(1);
									if (tail_k_q == KW'((1 << tail_lvl_q) - 1)) begin
										tail_lvl_q <= tail_lvl_q + LVW'(1);
										tail_k_q   <= '0;
									end else begin
										tail_k_q <= tail_k_q + KW'(1);
									end
									state_q <= S_UP_RD;
								end else if (lower(root_q, new_entry)) begin
									kept_q  <= 1'b1;
									lvl_q   <= '0;
									k_q     <= '0;
									pos_q   <= '0;
									state_q <= S_DN_RD;
								end
							end
							OP_POP: begin
								if (cnt_q == '0) begin
									perr_q <= 1'b1;
								end else begin
									cnt_q <= cnt_q - CW'(1);
									if (tail_k_q == '0) begin
										tail_lvl_q <= tail_lvl_q - LVW'(1);
										tail_k_q   <= KW'((1 << (tail_lvl_q - LVW'(1))) - 1);
									end else begin
										tail_k_q <= tail_k_q - KW'(1);
									end
									state_q <= S_POP_RD;
								end
							end
							OP_CLEAR: begin
								cnt_q      <= '0;
								tail_lvl_q <= '0;
								tail_k_q   <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (x_lt_p) begin
						lvl_q   <= lvl_q - LVW'(1);
						k_q     <= KW'(k_q >> 1);
						pos_q   <= PW'((pos_q - PW'(1)) >> 1);
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DN_RD: begin
					state_q <= l_ok ? S_DN_CMP : S_FIN;
				end
				S_DN_CMP: begin
					if (go_l || go_r) begin
						lvl_q   <= lvl_q + LVW'(1);
						k_q     <= KW'({k_q, go_r});
						pos_q   <= go_r ? PW'(r_pos) : PW'(l_pos);
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_POP_RD: begin
					state_q <= (cnt_q == '0) ? S_FIN : S_POP_LD;
				end
				S_POP_LD: begin
					x_q     <= tail_k_q[0] ? rd_odd : rd_even;
					lvl_q   <= '0;
					k_q     <= '0;
					pos_q   <= '0;
					state_q <= S_DN_RD;
				end
				S_FIN: begin
					done_q               <= 1'b1;
					result_q.root_score  <= (cnt_q != '0) ?
						$signed(root_q[EW-1 -: SCORE_BITS]) : '0;
					result_q.root_tag    <= (cnt_q != '0) ?
						TAG_PORT_BITS'(root_q[TAG_BITS-1:0]) : '0;
					result_q.entry_count <= cnt_ext[CAP_BITS-1:0];
					result_q.is_empty    <= (cnt_q == '0);
					result_q.was_kept    <= kept_q;
					result_q.pop_error   <= perr_q;
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign done      = done_q;
	assign result    = result_q;

	`BTKH_ASSERT(a_one_write, $onehot0(wr_sel))
	`BTKH_ASSERT(a_no_rw_clash, (rd_sel & wr_sel) == '0)
	`BTKH_ASSERT(a_count_bound, cnt_q <= CW'(DEPTH))
	`BTKH_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

endmodule

`default_nettype wire

// File: tb/top_k_heap_checker.sv
`default_nettype none

// Watches command, result and capacity channels, keeps its own copy of the heap
// and compares each result strobe with the oldest predicted report.
module top_k_heap_checker import bthm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire in_item_t            cmd,
	input  wire logic                done,
	input  wire out_item_t           result,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [CAP_BITS-1:0] cfg_data,
	output int                       bad_reports,
	output int                       reports_owed
);

	localparam int SLOTS = DEPTH_DEF;

	logic signed [SCORE_BITS-1:0] slot_score [SLOTS];
	logic [TAG_PORT_BITS-1:0]     slot_tag   [SLOTS];
	int                           held;
	logic [CAP_BITS-1:0]          cap_reg;
	out_item_t                    heap_reports [$];

	// zero acts as one, anything past the store acts as full depth
	function automatic int room();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > SLOTS)
			return SLOTS;
		return int'(cap_reg);
	endfunction

	function automatic void swap_slots(int a, int b);
		logic signed [SCORE_BITS-1:0] s;
		logic [TAG_PORT_BITS-1:0]     t;
		s = slot_score[a];
		t = slot_tag[a];
		slot_score[a] = slot_score[b];
		slot_tag[a] = slot_tag[b];
		slot_score[b] = s;
		slot_tag[b] = t;
	endfunction

	function automatic void sink_from(int pos);
		int l;
		int r;
		int best;
		while (pos < held) begin
			l = 2 * pos + 1;
			r = 2 * pos + 2;
			best = pos;
			if (l < held && slot_score[l] < slot_score[best])
				best = l;
			if (r < held && slot_score[r] < slot_score[best])
				best = r;
			if (best == pos)
				break;
			swap_slots(pos, best);
			pos = best;
		end
	endfunction

	// applies one operation to the heap copy and returns the report it should give
	function automatic out_item_t apply_heap_op(in_item_t it);
		out_item_t rep;
		int        pos;
		int        up;
		rep = '0;
		case (it.opcode)
		OP_PUSH: begin
			if (held < room()) begin
				slot_score[held] = $signed(it.entry_score);
				slot_tag[held] = it.entry_tag;
				pos = held;
				held++;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (!(slot_score[pos] < slot_score[up]))
						break;
					swap_slots(pos, up);
					pos = up;
				end
				rep.was_kept = 1'b1;
			end else if (slot_score[0] < $signed(it.entry_score)) begin
				slot_score[0] = $signed(it.entry_score);
				slot_tag[0] = it.entry_tag;
				sink_from(0);
				rep.was_kept = 1'b1;
			end
		end
		OP_POP: begin
			if (held == 0) begin
				rep.pop_error = 1'b1;
			end else begin
				held--;
				slot_score[0] = slot_score[held];
				slot_tag[0] = slot_tag[held];
				sink_from(0);
			end
		end
		OP_CLEAR: begin
			held = 0;
		end
		default: begin
		end
		endcase
		if (held > 0) begin
			rep.root_score = slot_score[0];
			rep.root_tag = slot_tag[0];
		end
		rep.entry_count = held[CAP_BITS-1:0];
		rep.is_empty = (held == 0);
		return rep;
	endfunction

	function automatic void log_bad(string what);
		bad_reports++;
		if (bad_reports <= 10)
			$display("%s", what);
	endfunction

	function automatic string show(out_item_t r);
		return $sformatf("score %0d tag %h count %0d empty %b kept %b err %b",
			$signed(r.root_score), r.root_tag, r.entry_count, r.is_empty,
			r.was_kept, r.pop_error);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			held = 0;
			cap_reg = CAP_RESET;
			bad_reports = 0;
			heap_reports.delete();
		end else begin
			// a result at this edge always belongs to an earlier item
			if (done) begin
				if (heap_reports.size() == 0) begin
					log_bad({"unexpected result: ", show(result)});
				end else begin
					want = heap_reports.pop_front();
					if (result !== want)
						log_bad({"mismatch: want ", show(want), " / got ", show(result)});
				end
			end
			// an item taken at the same edge as a write still sees the old capacity
			if (start && !busy)
				heap_reports = {heap_reports, apply_heap_op(cmd)};
			if (cfg_valid && cfg_ready)
				cap_reg = cfg_data;
		end
		reports_owed = heap_reports.size();
	end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
	import bthm_pkg::*;

	// no code for it in the package; the block must report and change nothing
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// cycles with no handshake of any kind before the run is called hung
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 80;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	in_item_t            cmd       = '0;
	logic                cfg_valid = 1'b0;
	logic [CAP_BITS-1:0] cfg_data  = '0;
	logic                busy;
	logic                done;
	logic                cfg_ready;
	out_item_t           result;

	int bad_reports;
	int reports_owed;
	int stall_run = 0;
	bit quiet     = 1'b0;

	// capacity and share of pushes per random phase; 127 and 0 hit the clamps,
	// and 0 / 2 follow fill-heavy phases so the count sits above the limit
	int cap_plan  [PHASES] = '{64, 1, 3, 127, 0, 7, 64, 2, 33, 64};
	int push_plan [PHASES] = '{90, 60, 70, 80, 55, 40, 88, 65, 75, 50};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bounded_top_k_min_heap dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	top_k_heap_checker heap_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.bad_reports (bad_reports),
		.reports_owed(reports_owed)
	);

	// watchdog: any accepted item, result or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_run <= 0;
		end else if (stall_run == STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			stall_run <= stall_run + 1;
		end
	end

	function automatic in_item_t heap_op(logic [1:0] op, logic [SCORE_BITS-1:0] score,
		logic [TAG_PORT_BITS-1:0] tag);
		in_item_t it;
		it.opcode = op;
		it.entry_score = score;
		it.entry_tag = tag;
		return it;
	endfunction

	// scores: extremes, a narrow band round zero (plenty of equal scores,
	// hence dropped pushes when full), otherwise anything
	function automatic logic [SCORE_BITS-1:0] pick_score();
		case ($urandom_range(0, 9))
		0: return 32'h7fff_ffff;
		1: return 32'h8000_0000;
		2, 3, 4: return 32'($urandom_range(0, 16)) - 32'd8;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [TAG_PORT_BITS-1:0] pick_tag();
		case ($urandom_range(0, 19))
		0: return '0;
		1: return '1;
		default: return $urandom;
		endcase
	endfunction

	// clears only in phases under 85 percent pushes, else the heap never fills
	function automatic in_item_t rand_item(int push_pct);
		int         roll;
		logic [1:0] op;
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			op = OP_PUSH;
		else if (roll < 96)
			op = OP_POP;
		else if (roll < 98)
			op = (push_pct < 85) ? OP_CLEAR : OP_POP;
		else
			op = OP_UNUSED;
		return heap_op(op, pick_score(), pick_tag());
	endfunction

	// present one item and hold it until taken; start stays high for the next
	// item so back-to-back items go in on the cycle done is seen
	task automatic send_item(in_item_t it);
		if (!quiet && $urandom_range(0, 99) < 9) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= it;
		do @(posedge clk); while (busy);
	endtask

	// drop start and wait until every item has reported back
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (reports_owed != 0) @(negedge clk);
	endtask

	// capacity may only change with the block idle
	task automatic write_capacity(logic [CAP_BITS-1:0] cap);
		settle();
		if (!quiet && $urandom_range(0, 99) < 9)
			@(negedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset capacity of 64
		send_item(heap_op(OP_POP, 32'd0, 32'h0));              // pop on empty heap
		send_item(heap_op(OP_PUSH, 32'h7fff_ffff, 32'hffff_ffff));
		send_item(heap_op(OP_PUSH, 32'h8000_0000, 32'h0000_0000));
		send_item(heap_op(OP_PUSH, 32'd0, 32'h5a5a_a5a5));
		send_item(heap_op(OP_UNUSED, 32'h1234_5678, 32'hdead_beef));
		send_item(heap_op(OP_POP, 32'd0, 32'h0));
		send_item(heap_op(OP_POP, 32'd0, 32'h0));
		send_item(heap_op(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff));

		// two slots: fill, then equal, lower and higher scores against a full heap
		write_capacity(7'd2);
		send_item(heap_op(OP_PUSH, 32'd10, 32'h0000_000a));
		send_item(heap_op(OP_PUSH, 32'd20, 32'h0000_0014));
		send_item(heap_op(OP_PUSH, 32'd10, 32'h1111_1111)); // equal to root: dropped
		send_item(heap_op(OP_PUSH, 32'd5, 32'h2222_2222));  // below root: dropped
		send_item(heap_op(OP_PUSH, 32'd15, 32'h3333_3333)); // replaces root

		// zero acts as one and leaves the count above the limit
		write_capacity(7'd0);
		send_item(heap_op(OP_PUSH, 32'd16, 32'h4444_4444));
		send_item(heap_op(OP_PUSH, 32'hffff_ffff, 32'h5555_5555));
		send_item(heap_op(OP_POP, 32'd0, 32'h0));
		send_item(heap_op(OP_POP, 32'd0, 32'h0));
		send_item(heap_op(OP_POP, 32'd0, 32'h0));

		// random phases; the heap carries over from one to the next
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(cap_plan[p][CAP_BITS-1:0]);
			quiet = (p == 6);                                  // long stretch without gaps
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(rand_item(push_plan[p]));
		end

		settle();
		repeat (20) @(negedge clk);                            // catch stray results
		if (bad_reports == 0 && reports_owed == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
